[src/mos_pkg.sv]
// Shared constants, types and helpers for the Morton order sorter.
// No dependencies; the design modules of the block import this package.
`timescale 1ns / 1ps
`default_nettype none
package mos_pkg;
    localparam int MAX_POINTS = 64;
    localparam int AXIS_BITS  = 21;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int KEY_W      = 3 * AXIS_BITS;
    localparam int QUO_W      = AXIS_BITS + 1;
    localparam int NUM_W      = 32 + AXIS_BITS + 2;
    localparam logic [AXIS_BITS-1:0] QMAX = {AXIS_BITS{1'b1}};

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_key_wr;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
        logic             dropped;
    } t_sort_ctl;

    function automatic logic [KEY_W-1:0] interleave(
        input logic [AXIS_BITS-1:0] x,
        input logic [AXIS_BITS-1:0] y,
        input logic [AXIS_BITS-1:0] z
    );
        logic [KEY_W-1:0] k;
        k = '0;
        for (int b = 0; b < AXIS_BITS; b++) begin
            k[3*b]   = x[b];
            k[3*b+1] = y[b];
            k[3*b+2] = z[b];
        end
        return k;
    endfunction
endpackage
`default_nettype wire

[src/mos_if.sv]
// Valid/ready channel interfaces for points in and sorted indices out.
// Has no dependencies; the index width is written out as six bits.
`timescale 1ns / 1ps
`default_nettype none
interface mos_pt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
    logic               final_point;
    modport source (output valid, x_coord, y_coord, z_coord, final_point, input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, final_point, output ready);
endinterface

interface mos_idx_if;
    logic       valid;
    logic       ready;
    logic [5:0] point_index;
    logic       run_end;
    logic       overflowed;
    modport source (output valid, point_index, run_end, overflowed, input ready);
    modport sink   (input valid, point_index, run_end, overflowed, output ready);
endinterface
`default_nettype wire

[src/mos_quant.sv]
// One-axis quantiser: clamps to the bounding box, scales by 2^AXIS_BITS-1 and
// divides by the range with a restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mos_quant
    import mos_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [31:0]   i_val,
    input  wire logic signed [31:0]   i_min,
    input  wire logic signed [31:0]   i_max,
    output logic                      o_done,
    output logic [AXIS_BITS-1:0]      o_q
);
    typedef enum logic [3:0] {
        Q_IDLE = 4'b0001,
        Q_MUL  = 4'b0010,
        Q_DIV  = 4'b0100,
        Q_DONE = 4'b1000
    } t_qstate;

    localparam int STEP_W = $clog2(QUO_W + 1);

    t_qstate               r_state;
    logic [31:0]           r_range;
    logic [31:0]           r_diff;
    logic [32:0]           r_rem;
    logic [QUO_W-1:0]      r_sh;
    logic [QUO_W-1:0]      r_quo;
    logic [STEP_W-1:0]     r_step;
    logic [AXIS_BITS-1:0]  r_q;

    logic [32:0]           w_range;
    logic [32:0]           w_diff;
    logic [NUM_W-3:0]      w_prod;
    logic [NUM_W-1:0]      w_num;
    logic [33:0]           w_trial;
    logic [33:0]           w_div;
    logic                  w_ge;

    always_comb begin
        w_range = {i_max[31], i_max} - {i_min[31], i_min};
        w_diff  = {i_val[31], i_val} - {i_min[31], i_min};
        w_prod  = {r_diff, {AXIS_BITS{1'b0}}} - {{AXIS_BITS{1'b0}}, r_diff};
        w_num   = {1'b0, w_prod, 1'b0} + {{(NUM_W-32){1'b0}}, r_range};
        w_div   = {1'b0, r_range, 1'b0};
        w_trial = {r_rem, r_sh[QUO_W-1]};
        w_ge    = (w_trial >= w_div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
        end else begin
            case (r_state)
                Q_IDLE: begin
                    if (i_start) begin
                        r_range <= w_range[31:0];
                        if (w_diff[32]) begin
                            r_diff <= '0;
                        end else if (w_diff[31:0] > w_range[31:0]) begin
                            r_diff <= w_range[31:0];
                        end else begin
                            r_diff <= w_diff[31:0];
                        end
                        r_state <= Q_MUL;
                    end
                end
                Q_MUL: begin
                    r_rem   <= w_num[NUM_W-1:QUO_W];
                    r_sh    <= w_num[QUO_W-1:0];
                    r_quo   <= '0;
                    r_step  <= '0;
                    r_state <= Q_DIV;
                end
                Q_DIV: begin
                    r_rem  <= w_ge ? 33'(w_trial - w_div) : w_trial[32:0];
                    r_sh   <= {r_sh[QUO_W-2:0], 1'b0};
                    r_quo  <= {r_quo[QUO_W-2:0], w_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(QUO_W - 1)) begin
                        r_state <= Q_DONE;
                    end
                end
                Q_DONE: begin
                    if (r_range == '0) begin
                        r_q <= '0;
                    end else if (r_quo > {1'b0, QMAX}) begin
                        r_q <= QMAX;
                    end else begin
                        r_q <= r_quo[AXIS_BITS-1:0];
                    end
                    r_state <= Q_IDLE;
                end
                default: r_state <= Q_IDLE;
            endcase
        end
    end

    // The result register is loaded on the edge that leaves Q_DONE.
    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == Q_DONE);
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule
`default_nettype wire

[src/mos_sorter.sv]
// Key memory with a stable insertion sort and the sorted index output.
// Depends on mos_pkg and the mos_idx_if interface.
`timescale 1ns / 1ps
`default_nettype none
module mos_sorter
    import mos_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_key_wr   i_key_wr,
    input  wire t_sort_ctl i_ctl,
    output logic           o_done,
    mos_idx_if.source      o_idx
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_FETCH = 8'b00000010,
        S_CUR   = 8'b00000100,
        S_CMP   = 8'b00001000,
        S_PLACE = 8'b00010000,
        S_ORD   = 8'b00100000,
        S_OLOAD = 8'b01000000,
        S_OHOLD = 8'b10000000
    } t_sstate;

    t_entry           r_mem [MAX_POINTS];
    t_entry           r_rd;
    t_sstate          r_state;
    t_entry           r_cur;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] r_last;
    logic             r_drop;
    logic             r_valid;
    logic [IDX_W-1:0] r_pidx;
    logic             r_end;
    logic             r_done;

    logic             w_we;
    logic [IDX_W-1:0] w_wa;
    t_entry           w_wd;
    logic [IDX_W-1:0] w_ra;

    always_comb begin
        w_we = 1'b0;
        w_wa = r_j;
        w_wd = r_cur;
        w_ra = r_i;
        case (r_state)
            S_IDLE: begin
                w_we = i_key_wr.en;
                w_wa = i_key_wr.addr;
                w_wd = i_key_wr.data;
            end
            S_CUR: w_ra = r_i - 1'b1;
            S_CMP: begin
                w_we = 1'b1;
                if (r_rd.key > r_cur.key) begin
                    w_wd = r_rd;
                    w_ra = r_j - 2'd2;
                end else begin
                    w_ra = r_i + 1'b1;
                end
            end
            S_PLACE: begin
                w_we = 1'b1;
                w_wa = '0;
                w_ra = r_i + 1'b1;
            end
            S_ORD: w_ra = r_k;
            default: w_ra = r_i;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_last <= IDX_W'(i_ctl.count - 1'b1);
                        r_drop <= i_ctl.dropped;
                        r_i    <= IDX_W'(1);
                        r_k    <= '0;
                        r_state <= (i_ctl.count == CNT_W'(1)) ? S_ORD : S_FETCH;
                    end
                end
                S_FETCH: r_state <= S_CUR;
                S_CUR: begin
                    r_cur   <= r_rd;
                    r_j     <= r_i;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_rd.key > r_cur.key) begin
                        r_j <= r_j - 1'b1;
                        if (r_j == IDX_W'(1)) begin
                            r_state <= S_PLACE;
                        end
                    end else if (r_i == r_last) begin
                        r_state <= S_ORD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CUR;
                    end
                end
                S_PLACE: begin
                    if (r_i == r_last) begin
                        r_state <= S_ORD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CUR;
                    end
                end
                S_ORD: r_state <= S_OLOAD;
                S_OLOAD: begin
                    r_pidx  <= r_rd.idx;
                    r_end   <= (r_k == r_last);
                    r_valid <= 1'b1;
                    r_state <= S_OHOLD;
                end
                S_OHOLD: begin
                    if (o_idx.ready) begin
                        r_valid <= 1'b0;
                        if (r_end) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done            = r_done;
    assign o_idx.valid       = r_valid;
    assign o_idx.point_index = 6'(r_pidx);
    assign o_idx.run_end     = r_end;
    assign o_idx.overflowed  = r_drop;
endmodule
`default_nettype wire

[src/morton_order_sorter.sv]
// Top level of the Morton order sorter: point store, bounds, key generation.
// Depends on mos_pkg, mos_if, mos_quant and mos_sorter.
//
// Points enter on i_pt, one item per cycle while i_pt.ready is high. Each
// point is written to the coordinate memory and folded into the per-axis
// minimum and maximum. Points beyond 64 in a set are dropped and flagged.
// An item with final_point set (stored or dropped) closes the set: i_pt.ready
// falls and the block quantises every stored point, one point at a time
// through three parallel dividers, then runs an insertion sort over the key
// memory, one memory compare per cycle while an entry moves down.
// The sorted arrival indices then leave on o_idx, each held until it is
// taken; run_end marks the last and overflowed reports dropped points.
// A stalled receiver simply holds the current index; nothing is lost.
// When the last index is taken, the bounds and counters clear and i_pt.ready
// returns. Synchronous reset clears the control state; no memory clearing
// pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module morton_order_sorter
    import mos_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mos_pt_if.sink     i_pt,
    mos_idx_if.source  o_idx
);
    typedef enum logic [4:0] {
        T_LOAD  = 5'b00001,
        T_KREAD = 5'b00010,
        T_KSTRT = 5'b00100,
        T_KWAIT = 5'b01000,
        T_SORT  = 5'b10000
    } t_tstate;

    t_tstate            r_state;
    logic [95:0]        r_cmem [MAX_POINTS];
    logic [95:0]        r_crd;
    logic signed [31:0] r_min [3];
    logic signed [31:0] r_max [3];
    logic [CNT_W-1:0]   r_count;
    logic               r_drop;
    logic [IDX_W-1:0]   r_ki;
    logic               r_qstart;
    t_key_wr            r_kw;
    t_sort_ctl          r_ctl;

    logic               w_acc;
    logic               w_store;
    logic signed [31:0] w_v [3];
    logic [AXIS_BITS-1:0] w_q [3];
    logic [2:0]         w_qdone;
    logic               w_sdone;

    assign i_pt.ready = (r_state == T_LOAD);
    assign w_acc      = i_pt.valid && i_pt.ready;
    assign w_store    = w_acc && (r_count < CNT_W'(MAX_POINTS));
    assign w_v[0]     = i_pt.x_coord;
    assign w_v[1]     = i_pt.y_coord;
    assign w_v[2]     = i_pt.z_coord;

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_cmem[r_count[IDX_W-1:0]] <= {i_pt.z_coord, i_pt.y_coord, i_pt.x_coord};
        end
        r_crd <= r_cmem[r_ki];
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        mos_quant u_quant (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_qstart),
            .i_val   (r_crd[32*a +: 32]),
            .i_min   (r_min[a]),
            .i_max   (r_max[a]),
            .o_done  (w_qdone[a]),
            .o_q     (w_q[a])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || w_sdone) begin
                r_min[a] <= 32'sh7fffffff;
                r_max[a] <= 32'sh80000000;
            end else if (w_store) begin
                if (w_v[a] < r_min[a]) begin
                    r_min[a] <= w_v[a];
                end
                if (w_v[a] > r_max[a]) begin
                    r_max[a] <= w_v[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_LOAD;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_qstart <= 1'b0;
            r_kw.en  <= 1'b0;
            r_ctl.start <= 1'b0;
        end else begin
            r_qstart    <= 1'b0;
            r_kw.en     <= 1'b0;
            r_ctl.start <= 1'b0;
            case (r_state)
                T_LOAD: begin
                    if (w_store) begin
                        r_count <= r_count + 1'b1;
                    end else if (w_acc) begin
                        r_drop <= 1'b1;
                    end
                    if (w_acc && i_pt.final_point) begin
                        r_ki    <= '0;
                        r_state <= T_KREAD;
                    end
                end
                T_KREAD: r_state <= T_KSTRT;
                T_KSTRT: begin
                    r_qstart <= 1'b1;
                    r_state  <= T_KWAIT;
                end
                T_KWAIT: begin
                    if (&w_qdone) begin
                        r_kw.en       <= 1'b1;
                        r_kw.addr     <= r_ki;
                        r_kw.data.key <= interleave(w_q[0], w_q[1], w_q[2]);
                        r_kw.data.idx <= r_ki;
                        if (r_ki == IDX_W'(r_count - 1'b1)) begin
                            r_ctl.start   <= 1'b1;
                            r_ctl.count   <= r_count;
                            r_ctl.dropped <= r_drop;
                            r_state       <= T_SORT;
                        end else begin
                            r_ki    <= r_ki + 1'b1;
                            r_state <= T_KREAD;
                        end
                    end
                end
                T_SORT: begin
                    if (w_sdone) begin
                        r_count <= '0;
                        r_drop  <= 1'b0;
                        r_state <= T_LOAD;
                    end
                end
                default: r_state <= T_LOAD;
            endcase
        end
    end

    mos_sorter u_sorter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key_wr (r_kw),
        .i_ctl    (r_ctl),
        .o_done   (w_sdone),
        .o_idx    (o_idx)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");
    a_no_out_while_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_idx.valid |-> (r_state == T_SORT))
        else $error("index emitted outside the sort phase");
    a_quant_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_qdone != 3'b000) |-> (w_qdone == 3'b111) && (r_state == T_KWAIT))
        else $error("quantisers out of step");
    a_sort_has_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.start |-> (r_ctl.count != '0))
        else $error("sort started on an empty set");
endmodule
`default_nettype wire
